// ===== hdl/ir_alternating_pulse_decoder_defines.svh =====
// assertion macros for the alternating pulse decoder
`ifndef IR_ALTERNATING_PULSE_DECODER_DEFINES_SVH
`define IR_ALTERNATING_PULSE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define APD_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apd assertion failed");
// next-cycle implication, disabled during reset
`define APD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apd assertion failed");
`else
`define APD_ASSERT(lbl, clk, rst, ante, cons)
`define APD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/irapd_pkg.sv =====
package irapd_pkg;

  localparam int DUR_W     = 16;
  localparam int CODE_W    = 16;
  localparam int TOL_W     = 7;
  localparam int EXCESS_W  = 9;
  localparam int IDX_W     = 6;
  localparam int US_W      = 13;
  localparam int FAC_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;

  // nominal lengths in microseconds
  localparam logic [US_W-1:0] HDR_MARK_US  = 13'd6000;
  localparam logic [US_W-1:0] HDR_SPACE_US = 13'd1200;
  localparam logic [US_W-1:0] ONE_US       = 13'd1200;
  localparam logic [US_W-1:0] ZERO_US      = 13'd580;

  localparam logic [TOL_W-1:0]    PCT_FULL     = 7'd100;
  localparam logic [TOL_W-1:0]    TOL_RESET    = 7'd25;
  localparam logic [EXCESS_W-1:0] EXCESS_RESET = 9'd100;

  // frame positions
  localparam logic [IDX_W-1:0] IDX_HDR_MARK   = 6'd1;
  localparam logic [IDX_W-1:0] IDX_HDR_SPACE  = 6'd2;
  localparam logic [IDX_W-1:0] IDX_DATA_FIRST = 6'd3;
  localparam logic [IDX_W-1:0] IDX_MAX        = 6'd63;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXCESS    = 1'b1;

  typedef struct packed {
    logic [DUR_W-1:0] duration_ticks;
    logic             end_of_capture;
  } in_word_t;

  typedef struct packed {
    logic              frame_ok;
    logic [CODE_W-1:0] code;
  } out_word_t;

  typedef struct packed {
    logic [TOL_W-1:0]    tolerance_pct;
    logic [EXCESS_W-1:0] mark_excess_us;
  } cfg_t;

endpackage

// ===== hdl/irapd_match.sv =====
module irapd_match import irapd_pkg::*; #(
  parameter int TICK_US = 50
) (
  input  logic [DUR_W-1:0] duration,
  input  logic [US_W-1:0]  nominal_us,
  input  logic             is_mark,
  input  cfg_t             cfg,
  output logic             hit
);

  localparam int DIV    = 100 * TICK_US;
  localparam int DIV_W  = $clog2(DIV + 1);
  localparam int X_W    = US_W + FAC_W;
  localparam int PROD_W = DUR_W + 1 + DIV_W;

  logic [US_W-1:0]   adj_us;
  logic [FAC_W-1:0]  lo_fac;
  logic [FAC_W-1:0]  hi_fac;
  logic [X_W-1:0]    x_lo;
  logic [X_W-1:0]    x_hi;
  logic [PROD_W-1:0] d_scaled;

  always_comb begin
    if (is_mark) begin
      adj_us = nominal_us + US_W'(cfg.mark_excess_us);
    end else if (nominal_us > US_W'(cfg.mark_excess_us)) begin
      adj_us = nominal_us - US_W'(cfg.mark_excess_us);
    end else begin
      adj_us = '0;
    end
  end

  assign lo_fac = (cfg.tolerance_pct >= PCT_FULL) ? '0 :
                  FAC_W'(PCT_FULL - cfg.tolerance_pct);
  assign hi_fac = FAC_W'(cfg.tolerance_pct) + FAC_W'(PCT_FULL);

  assign x_lo     = X_W'(adj_us) * X_W'(lo_fac);
  assign x_hi     = X_W'(adj_us) * X_W'(hi_fac);
  assign d_scaled = PROD_W'(duration) * PROD_W'(DIV);

  // floor(x_lo/div) <= d  and  d <= floor(x_hi/div) + 1, without dividing
  assign hit = (PROD_W'(x_lo) < d_scaled + PROD_W'(DIV)) &&
               (d_scaled <= PROD_W'(x_hi) + PROD_W'(DIV));

endmodule

// ===== hdl/ir_alternating_pulse_decoder.sv =====
// path: a closing word is held in the input register, and its result word is
//   registered in the result register, where it waits until taken
// throughput: one input word per cycle; a frame-closing word waits only while
//   the result register is full and stalled
// reset: synchronous active-high rst clears frame state, the valid flags of both
//   word registers and restores tolerance 25 % and mark excess 100 us
`include "ir_alternating_pulse_decoder_defines.svh"

module ir_alternating_pulse_decoder import irapd_pkg::*; #(
  parameter int CODE_BITS = 16,
  parameter int TICK_US   = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  // input word channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  in_word_t             item,
  // result word channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output out_word_t            result,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam logic [IDX_W-1:0] DATA_END  = IDX_W'(3 + CODE_BITS);
  localparam logic [IDX_W-1:0] FRAME_LEN = IDX_W'(4 + CODE_BITS);

  // configuration registers
  cfg_t cfg;

  // input register
  in_word_t item_q;
  logic     item_q_valid;
  logic     advance;

  // frame state
  logic [IDX_W-1:0]     entry_index;
  logic [CODE_BITS-1:0] shift_value;
  logic                 mismatch_seen;

  logic [IDX_W-1:0]     entry_index_next;
  logic [CODE_BITS-1:0] shift_value_next;
  logic                 mismatch_seen_next;

  // match inputs and outputs
  logic [US_W-1:0] nominal_a;
  logic            is_mark;
  logic            hit_a;
  logic            hit_b;
  logic            in_header;
  logic            in_data;
  logic            frame_good;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance_pct  <= TOL_RESET;
      cfg.mark_excess_us <= EXCESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE: cfg.tolerance_pct  <= cfg_data[TOL_W-1:0];
        REG_EXCESS:    cfg.mark_excess_us <= cfg_data[EXCESS_W-1:0];
        default: ;
      endcase
    end
  end

  // a word that closes no frame always moves on; a closing word needs the
  // result register free or being emptied this cycle
  assign advance    = item_q_valid &&
                      (!item_q.end_of_capture || !result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  // pick the nominal for this position: header mark, header space or a one bit;
  // the zero-bit compare runs alongside
  assign in_header = (entry_index == IDX_HDR_MARK) || (entry_index == IDX_HDR_SPACE);
  assign in_data   = (entry_index >= IDX_DATA_FIRST) && (entry_index < DATA_END);

  always_comb begin
    if (entry_index == IDX_HDR_MARK) begin
      nominal_a = HDR_MARK_US;
      is_mark   = 1'b1;
    end else if (entry_index == IDX_HDR_SPACE) begin
      nominal_a = HDR_SPACE_US;
      is_mark   = 1'b0;
    end else begin
      nominal_a = ONE_US;
      // data starts on a mark at an odd position
      is_mark   = entry_index[0];
    end
  end

  irapd_match #(.TICK_US(TICK_US)) u_match_a (
    .duration   (item_q.duration_ticks),
    .nominal_us (nominal_a),
    .is_mark    (is_mark),
    .cfg        (cfg),
    .hit        (hit_a)
  );

  irapd_match #(.TICK_US(TICK_US)) u_match_b (
    .duration   (item_q.duration_ticks),
    .nominal_us (ZERO_US),
    .is_mark    (is_mark),
    .cfg        (cfg),
    .hit        (hit_b)
  );

  // frame state update; a one wins when both bit lengths match
  always_comb begin
    mismatch_seen_next = mismatch_seen ||
                         (in_header && !hit_a) ||
                         (in_data && !hit_a && !hit_b);
    shift_value_next   = in_data ? ((shift_value << 1) | CODE_BITS'(hit_a)) : shift_value;
    entry_index_next   = (entry_index == IDX_MAX) ? entry_index : entry_index + 1'b1;
    frame_good         = (entry_index_next == FRAME_LEN) && !mismatch_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_index   <= '0;
      shift_value   <= '0;
      mismatch_seen <= 1'b0;
    end else if (advance) begin
      if (item_q.end_of_capture) begin
        entry_index   <= '0;
        shift_value   <= '0;
        mismatch_seen <= 1'b0;
      end else begin
        entry_index   <= entry_index_next;
        shift_value   <= shift_value_next;
        mismatch_seen <= mismatch_seen_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && item_q.end_of_capture) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_q.end_of_capture) begin
      result.frame_ok <= frame_good;
      result.code     <= frame_good ? CODE_W'(shift_value_next) : '0;
    end
  end

  // a failed frame never carries a code
  `APD_ASSERT(a_fail_code_zero, clk, rst, result_valid && !result.frame_ok, result.code == '0)
  // nothing is shifted before the data section
  `APD_ASSERT(a_header_no_bits, clk, rst, entry_index < IDX_DATA_FIRST, shift_value == '0)
  // a closing word restarts the frame
  `APD_ASSERT_NEXT(a_frame_restart, clk, rst, advance && item_q.end_of_capture,
                   entry_index == '0 && !mismatch_seen && result_valid)
  // the input side only waits on a closing word behind a held result
  `APD_ASSERT(a_stall_cause, clk, rst, item_stall,
              item_q.end_of_capture && result_valid && result_stall)

endmodule
